[src/char_video_interface_unit_defines.svh]
// assertion helpers for the character video interface unit
`ifndef CHAR_VIDEO_INTERFACE_UNIT_DEFINES_SVH
`define CHAR_VIDEO_INTERFACE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CVI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CVI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/cvi_pkg.sv]
package cvi_pkg;

  localparam int PAGE_DEPTH = 2048;
  localparam int CHAR_DEPTH = 4096;
  localparam int CHAR_WIDTH = 6;

  localparam int PAGE_AW = $clog2(PAGE_DEPTH);
  localparam int CHAR_AW = $clog2(CHAR_DEPTH);
  localparam int CLR_W   = CHAR_AW;

  localparam int CMD_W   = 4;
  localparam int OFS_W   = 11;
  localparam int VAL_W   = 16;
  localparam int CELL_W  = 10;
  localparam int ROW_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int COLOR_W = 3;
  localparam int LPC_W   = 5;
  localparam int PTR_W   = 11;
  localparam int FMT_W   = 5;

  // format_mode bit positions
  localparam int FM_CMEM   = 0;
  localparam int FM_LINE9  = 1;
  localparam int FM_LINE16 = 2;
  localparam int FM_DBLPG  = 3;
  localparam int FM_FRESV  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_OUT3    = 4'd0,
    CMD_OUT5    = 4'd1,
    CMD_OUT6    = 4'd2,
    CMD_OUT7    = 4'd3,
    CMD_PAGE_WR = 4'd4,
    CMD_PAGE_RD = 4'd5,
    CMD_CHAR_WR = 4'd6,
    CMD_CHAR_RD = 4'd7,
    CMD_RENDER  = 4'd8
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic char_go;
    logic load_out;
  } cvi_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic needs_char;
  } cvi_sts_t;

  function automatic logic [LPC_W-1:0] line_count(input logic [FMT_W-1:0] fm);
    logic [LPC_W-1:0] n;
    if (fm[FM_LINE16] && !fm[FM_DBLPG]) n = LPC_W'(16);
    else if (!fm[FM_LINE9])             n = LPC_W'(9);
    else                                n = LPC_W'(8);
    return n;
  endfunction

endpackage

[src/cvi_in_if.sv]
interface cvi_in_if;
  logic                        valid;
  logic                        ready;
  logic [cvi_pkg::CMD_W-1:0]   command;
  logic [cvi_pkg::OFS_W-1:0]   offset;
  logic [cvi_pkg::VAL_W-1:0]   value;
  logic [cvi_pkg::CELL_W-1:0]  cell_req;
  logic [cvi_pkg::ROW_W-1:0]   row;

  modport source(output valid, command, offset, value, cell_req, row, input ready);
  modport sink(input valid, command, offset, value, cell_req, row, output ready);
endinterface

[src/cvi_out_if.sv]
interface cvi_out_if;
  logic                         valid;
  logic                         ready;
  logic [cvi_pkg::BYTE_W-1:0]   read_data;
  logic [cvi_pkg::CHAR_WIDTH-1:0] pixel_mask;
  logic [cvi_pkg::COLOR_W-1:0]  fore_color;
  logic [cvi_pkg::COLOR_W-1:0]  back_color;
  logic                         blank;
  logic [cvi_pkg::LPC_W-1:0]    lines_per_char;
  logic                         double_horz;
  logic                         double_vert;

  modport source(output valid, read_data, pixel_mask, fore_color, back_color, blank,
                 lines_per_char, double_horz, double_vert, input ready);
  modport sink(input valid, read_data, pixel_mask, fore_color, back_color, blank,
               lines_per_char, double_horz, double_vert, output ready);
endinterface

[src/cvi_ctrl.sv]
module cvi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cvi_pkg::cvi_sts_t sts,
  output cvi_pkg::cvi_ctl_t ctl
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHAR,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free, load, ready, accept;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    load     = (state_r == ST_FIN) && out_free;
    ready    = (state_r == ST_IDLE) || load;
    accept   = in_valid && ready;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = sts.needs_char ? ST_CHAR : ST_FIN;
      end
      ST_CHAR: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // result leaves and the next beat may come in on the same edge
        if (load) begin
          if (accept) state_nxt = sts.needs_char ? ST_CHAR : ST_FIN;
          else        state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    if (load)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    ctl.clear    = (state_r == ST_CLEAR);
    ctl.accept   = accept;
    ctl.char_go  = (state_r == ST_CHAR);
    ctl.load_out = load;
  end

  assign in_ready  = ready;
  assign out_valid = out_valid_r;

endmodule

[src/cvi_datapath.sv]
module cvi_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cvi_pkg::cvi_ctl_t                 ctl,
  output cvi_pkg::cvi_sts_t                 sts,
  input  logic [cvi_pkg::CMD_W-1:0]         in_command,
  input  logic [cvi_pkg::OFS_W-1:0]         in_offset,
  input  logic [cvi_pkg::VAL_W-1:0]         in_value,
  input  logic [cvi_pkg::CELL_W-1:0]        in_cell_req,
  input  logic [cvi_pkg::ROW_W-1:0]         in_row,
  output logic [cvi_pkg::BYTE_W-1:0]        out_read_data,
  output logic [cvi_pkg::CHAR_WIDTH-1:0]    out_pixel_mask,
  output logic [cvi_pkg::COLOR_W-1:0]       out_fore_color,
  output logic [cvi_pkg::COLOR_W-1:0]       out_back_color,
  output logic                              out_blank,
  output logic [cvi_pkg::LPC_W-1:0]         out_lines_per_char,
  output logic                              out_double_horz,
  output logic                              out_double_vert
);

  localparam logic [1:0] CFMT_A = 2'd0;
  localparam logic [1:0] CFMT_B = 2'd1;

  // mode registers
  logic [cvi_pkg::BYTE_W-1:0] display_mode_r;
  logic [cvi_pkg::FMT_W-1:0]  format_mode_r;
  logic [cvi_pkg::PTR_W-1:0]  page_ptr_r;
  logic [cvi_pkg::PTR_W-1:0]  home_r;
  logic [cvi_pkg::CLR_W-1:0]  clr_cnt_r;

  // held item
  cvi_pkg::cmd_t              cmd_r;
  logic [2:0]                 offset_lo_r;
  logic [cvi_pkg::BYTE_W-1:0] value_lo_r;
  logic [cvi_pkg::ROW_W-1:0]  row_r;

  // memories
  logic [cvi_pkg::BYTE_W-1:0] page_mem [cvi_pkg::PAGE_DEPTH];
  logic [cvi_pkg::BYTE_W-1:0] char_mem [cvi_pkg::CHAR_DEPTH];
  logic [cvi_pkg::BYTE_W-1:0] page_rd_r;
  logic [cvi_pkg::BYTE_W-1:0] char_rd_r;

  // result registers
  logic [cvi_pkg::BYTE_W-1:0]     read_data_r;
  logic [cvi_pkg::CHAR_WIDTH-1:0] pixel_mask_r;
  logic [cvi_pkg::COLOR_W-1:0]    fore_color_r;
  logic [cvi_pkg::COLOR_W-1:0]    back_color_r;
  logic                           blank_r;
  logic [cvi_pkg::LPC_W-1:0]      lpc_r;
  logic                           double_horz_r;
  logic                           double_vert_r;

  cvi_pkg::cmd_t              in_cmd;
  logic                       cmem;
  logic [cvi_pkg::PTR_W-1:0]  ptr_masked;
  logic [cvi_pkg::PAGE_AW-1:0] eff_ptr;
  logic [cvi_pkg::PTR_W-1:0]  render_sum;
  logic [cvi_pkg::PAGE_AW-1:0] page_addr;
  logic                       page_we, page_re;
  logic [cvi_pkg::BYTE_W-1:0] page_wdata;
  logic [cvi_pkg::CHAR_AW-1:0] char_addr;
  logic                       char_we, char_re;
  logic [cvi_pkg::BYTE_W-1:0] char_wdata;
  logic [cvi_pkg::LPC_W-1:0]  lpc;
  logic                       row_ok;
  logic                       ccb0, ccb1;
  logic [cvi_pkg::COLOR_W-1:0] fore;
  logic [cvi_pkg::BYTE_W-1:0] rd_sel;

  always_comb begin
    in_cmd     = cvi_pkg::cmd_t'(in_command);
    cmem       = format_mode_r[cvi_pkg::FM_CMEM];
    ptr_masked = format_mode_r[cvi_pkg::FM_DBLPG] ? page_ptr_r
                                                 : {1'b0, page_ptr_r[9:0]};
    eff_ptr    = ptr_masked[cvi_pkg::PAGE_AW-1:0];
    render_sum = home_r + cvi_pkg::PTR_W'(in_cell_req);
  end

  always_comb begin
    sts.clr_last   = (clr_cnt_r == cvi_pkg::CLR_W'(cvi_pkg::CHAR_DEPTH - 1));
    sts.needs_char = (in_cmd == cvi_pkg::CMD_CHAR_WR) || (in_cmd == cvi_pkg::CMD_CHAR_RD) ||
                     (in_cmd == cvi_pkg::CMD_RENDER);
  end

  // page port: clearing sweep, or the accepted beat's access
  always_comb begin
    page_addr  = eff_ptr;
    page_we    = 1'b0;
    page_re    = 1'b0;
    page_wdata = in_value[cvi_pkg::BYTE_W-1:0];
    if (ctl.clear) begin
      page_addr  = clr_cnt_r[cvi_pkg::PAGE_AW-1:0];
      page_we    = 1'b1;
      page_wdata = '0;
    end else if (ctl.accept) begin
      page_re = 1'b1;
      unique case (in_cmd)
        cvi_pkg::CMD_PAGE_WR: begin
          page_addr = cmem ? eff_ptr : in_offset[cvi_pkg::PAGE_AW-1:0];
          page_we   = 1'b1;
        end
        cvi_pkg::CMD_PAGE_RD: page_addr = cmem ? eff_ptr : in_offset[cvi_pkg::PAGE_AW-1:0];
        cvi_pkg::CMD_RENDER:  page_addr = render_sum[cvi_pkg::PAGE_AW-1:0];
        default:              page_addr = eff_ptr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (page_we) page_mem[page_addr] <= page_wdata;
    if (page_re) page_rd_r <= page_mem[page_addr];
  end

  // char port: code from the page read, then glyph row or low offset bits
  always_comb begin
    char_addr  = cvi_pkg::CHAR_AW'({page_rd_r, 1'b0, offset_lo_r});
    char_we    = 1'b0;
    char_re    = 1'b0;
    char_wdata = value_lo_r;
    if (ctl.clear) begin
      char_addr  = clr_cnt_r;
      char_we    = 1'b1;
      char_wdata = '0;
    end else if (ctl.char_go) begin
      char_re = 1'b1;
      if (cmd_r == cvi_pkg::CMD_RENDER) char_addr = cvi_pkg::CHAR_AW'({page_rd_r, row_r});
      char_we = (cmd_r == cvi_pkg::CMD_CHAR_WR) && cmem;
    end
  end

  always_ff @(posedge clk) begin
    if (char_we) char_mem[char_addr] <= char_wdata;
    if (char_re) char_rd_r <= char_mem[char_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_mode_r <= '0;
      format_mode_r  <= '0;
      page_ptr_r     <= '0;
      home_r         <= '0;
      clr_cnt_r      <= '0;
    end else begin
      if (ctl.clear) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (ctl.accept) begin
        unique case (in_cmd)
          cvi_pkg::CMD_OUT3: display_mode_r <= in_value[cvi_pkg::BYTE_W-1:0];
          cvi_pkg::CMD_OUT5: format_mode_r  <= {in_value[7], in_value[6], in_value[5],
                                                in_value[3], in_value[0]};
          cvi_pkg::CMD_OUT6: page_ptr_r     <= in_value[cvi_pkg::PTR_W-1:0];
          cvi_pkg::CMD_OUT7: home_r         <= {in_value[cvi_pkg::PTR_W-1:2], 2'b00};
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r       <= in_cmd;
      offset_lo_r <= in_offset[2:0];
      value_lo_r  <= in_value[cvi_pkg::BYTE_W-1:0];
      row_r       <= in_row;
    end
  end

  // result forming
  always_comb begin
    lpc    = cvi_pkg::line_count(format_mode_r);
    row_ok = (cvi_pkg::LPC_W'(row_r) < lpc);
    ccb0   = char_rd_r[6];
    ccb1   = char_rd_r[7];
    unique case (display_mode_r[6:5])
      CFMT_A:  fore = {ccb0, ccb1, 1'b0};
      CFMT_B:  fore = {ccb0, 1'b0, ccb1};
      default: fore = {1'b0, ccb0, ccb1};
    endcase
    unique case (cmd_r)
      cvi_pkg::CMD_PAGE_RD: rd_sel = page_rd_r;
      cvi_pkg::CMD_CHAR_RD: rd_sel = char_rd_r;
      default:              rd_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      read_data_r   <= rd_sel;
      pixel_mask_r  <= '0;
      fore_color_r  <= '0;
      if ((cmd_r == cvi_pkg::CMD_RENDER) && row_ok) begin
        fore_color_r <= fore;
        // display off keeps the colour but drops the pixels
        if (!display_mode_r[4]) pixel_mask_r <= char_rd_r[cvi_pkg::CHAR_WIDTH-1:0];
      end
      back_color_r  <= display_mode_r[2:0];
      blank_r       <= display_mode_r[4];
      lpc_r         <= lpc;
      double_horz_r <= !display_mode_r[7];
      double_vert_r <= !format_mode_r[cvi_pkg::FM_FRESV];
    end
  end

  assign out_read_data      = read_data_r;
  assign out_pixel_mask     = pixel_mask_r;
  assign out_fore_color     = fore_color_r;
  assign out_back_color     = back_color_r;
  assign out_blank          = blank_r;
  assign out_lines_per_char = lpc_r;
  assign out_double_horz    = double_horz_r;
  assign out_double_vert    = double_vert_r;

endmodule

[src/char_video_interface_unit.sv]
// Character video interface unit.
// in_bus carries one command per beat (register write, page RAM or character
// RAM access, or render of one glyph row); out_bus returns exactly one result
// beat per command, in order.
// Register writes, page writes, page reads and unused codes go from
// acceptance straight to the result register; character RAM access and
// render first take the page RAM read of the character code followed by
// the character RAM access. Sustained throughput is one command per cycle
// for those direct kinds while out_bus is not stalled; during the character
// RAM step no command is taken, the two synchronous RAM reads being serial.
// A result sits in an output register; the next command is accepted while it
// waits. When out_bus stalls, the unit finishes the command in hand, then
// holds it and stops accepting until the held result is taken.
// After reset both RAMs and all mode registers are cleared: a sweep writes
// zero to every entry, and in_bus.ready stays low until it is done.
`include "char_video_interface_unit_defines.svh"

module char_video_interface_unit (
  input logic      clk,
  input logic      rst_n,
  cvi_in_if.sink   in_bus,
  cvi_out_if.source out_bus
);

  cvi_pkg::cvi_ctl_t ctl;
  cvi_pkg::cvi_sts_t sts;

  cvi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  cvi_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .in_command         (in_bus.command),
    .in_offset          (in_bus.offset),
    .in_value           (in_bus.value),
    .in_cell_req        (in_bus.cell_req),
    .in_row             (in_bus.row),
    .out_read_data      (out_bus.read_data),
    .out_pixel_mask     (out_bus.pixel_mask),
    .out_fore_color     (out_bus.fore_color),
    .out_back_color     (out_bus.back_color),
    .out_blank          (out_bus.blank),
    .out_lines_per_char (out_bus.lines_per_char),
    .out_double_horz    (out_bus.double_horz),
    .out_double_vert    (out_bus.double_vert)
  );

  `CVI_ASSERT_NOW(a_no_accept_in_clear, ctl.clear, !in_bus.ready, "beat accepted during clear")
  `CVI_ASSERT_NOW(a_load_needs_room, ctl.load_out, (!out_bus.valid || out_bus.ready), "result overwritten")
  `CVI_ASSERT_NEXT(a_char_follows, (ctl.accept && sts.needs_char), ctl.char_go, "char step missing")
  `CVI_ASSERT_NEXT(a_load_shows, ctl.load_out, out_bus.valid, "loaded result not offered")

endmodule

[tb/char_video_interface_unit_checker.sv]
`timescale 1ns / 100ps

module char_video_interface_unit_checker
  import cvi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  cvi_in_if    in_mon,
  cvi_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [BYTE_W-1:0]     read_data;
    logic [CHAR_WIDTH-1:0] pixel_mask;
    logic [COLOR_W-1:0]    fore_color;
    logic [COLOR_W-1:0]    back_color;
    logic                  blank;
    logic [LPC_W-1:0]      lines_per_char;
    logic                  double_horz;
    logic                  double_vert;
  } video_beat_t;

  // shadow of the block's stores and mode registers
  logic [BYTE_W-1:0] page_mem  [PAGE_DEPTH];
  logic [BYTE_W-1:0] glyph_mem [CHAR_DEPTH];
  logic [PTR_W-1:0]  page_ptr;
  logic [PTR_W-1:0]  home_addr;
  logic [7:0]        disp_mode;
  logic [FMT_W-1:0]  fmt_mode;

  video_beat_t predicted_video_q[$];
  int          beat_no;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_error(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_error($sformatf("beat %0d %s got 0x%0h want 0x%0h", beat_no, name, got, want));
    end
  endtask

  function automatic logic [LPC_W-1:0] glyph_rows();
    if (fmt_mode[FM_LINE16] && !fmt_mode[FM_DBLPG]) return LPC_W'(16);
    if (!fmt_mode[FM_LINE9]) return LPC_W'(9);
    return LPC_W'(8);
  endfunction

  // pointer loses its top bit unless double page is on
  function automatic logic [PAGE_AW-1:0] ptr_slot();
    return {fmt_mode[FM_DBLPG] & page_ptr[PTR_W-1], page_ptr[PTR_W-2:0]};
  endfunction

  // code under the pointer picks the glyph, low offset bits pick rows 0..7
  function automatic logic [CHAR_AW-1:0] glyph_slot(input logic [OFS_W-1:0] ofs);
    return {page_mem[ptr_slot()], 1'b0, ofs[2:0]};
  endfunction

  function automatic video_beat_t predict_video_beat(
    input logic [CMD_W-1:0]  cmd,
    input logic [OFS_W-1:0]  ofs,
    input logic [VAL_W-1:0]  val,
    input logic [CELL_W-1:0] cell_idx,
    input logic [ROW_W-1:0]  row
  );
    video_beat_t       r;
    logic              cmem;
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] glyph;
    r = '0;
    cmem = fmt_mode[FM_CMEM];
    case (cmd)
      CMD_OUT3: disp_mode = val[7:0];
      CMD_OUT5: fmt_mode = {val[7], val[6], val[5], val[3], val[0]};
      CMD_OUT6: page_ptr = val[PTR_W-1:0];
      CMD_OUT7: home_addr = val[PTR_W-1:0] & 11'h7fc;
      CMD_PAGE_WR: page_mem[cmem ? ptr_slot() : ofs] = val[BYTE_W-1:0];
      CMD_PAGE_RD: r.read_data = page_mem[cmem ? ptr_slot() : ofs];
      CMD_CHAR_WR: begin
        if (cmem) glyph_mem[glyph_slot(ofs)] = val[BYTE_W-1:0];
      end
      CMD_CHAR_RD: r.read_data = glyph_mem[glyph_slot(ofs)];
      CMD_RENDER: begin
        if (LPC_W'(row) < glyph_rows()) begin
          code = page_mem[PAGE_AW'(home_addr + PTR_W'(cell_idx))];
          glyph = glyph_mem[{code, row}];
          case (disp_mode[6:5])
            2'd0:    r.fore_color = {glyph[6], glyph[7], 1'b0};
            2'd1:    r.fore_color = {glyph[6], 1'b0, glyph[7]};
            default: r.fore_color = {1'b0, glyph[6], glyph[7]};
          endcase
          if (!disp_mode[4]) r.pixel_mask = glyph[CHAR_WIDTH-1:0];
        end
      end
      default: ;
    endcase
    r.back_color = disp_mode[2:0];
    r.blank = disp_mode[4];
    r.lines_per_char = glyph_rows();
    r.double_horz = ~disp_mode[7];
    r.double_vert = ~fmt_mode[FM_FRESV];
    return r;
  endfunction

  always @(posedge clk) begin
    video_beat_t want;
    if (!rst_n) begin
      foreach (page_mem[i]) page_mem[i] = '0;
      foreach (glyph_mem[i]) glyph_mem[i] = '0;
      page_ptr = '0;
      home_addr = '0;
      disp_mode = '0;
      fmt_mode = '0;
      predicted_video_q.delete();
      beat_no = 0;
    end else begin
      // result beats belong to earlier commands, so check before predicting
      if (out_mon.valid && out_mon.ready) begin
        if (predicted_video_q.size() == 0) begin
          report_error($sformatf("result beat %0d with no command outstanding", beat_no));
        end else begin
          want = predicted_video_q.pop_front();
          check_field("read_data", out_mon.read_data, want.read_data);
          check_field("pixel_mask", out_mon.pixel_mask, want.pixel_mask);
          check_field("fore_color", out_mon.fore_color, want.fore_color);
          check_field("back_color", out_mon.back_color, want.back_color);
          check_field("blank", out_mon.blank, want.blank);
          check_field("lines_per_char", out_mon.lines_per_char, want.lines_per_char);
          check_field("double_horz", out_mon.double_horz, want.double_horz);
          check_field("double_vert", out_mon.double_vert, want.double_vert);
        end
        beat_no++;
      end
      if (in_mon.valid && in_mon.ready) begin
        predicted_video_q.push_back(predict_video_beat(in_mon.command, in_mon.offset,
                                                       in_mon.value, in_mon.cell_req,
                                                       in_mon.row));
      end
    end
    pending = predicted_video_q.size();
  end

endmodule

[tb/char_video_interface_unit_tb.sv]
`timescale 1ns / 100ps

module char_video_interface_unit_tb;
  import cvi_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 11;
  localparam int ITEM_TARGET  = 1500;
  localparam int CALM_ITEMS   = 200;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int RUN_LIMIT_NS = 5_000_000;

  logic clk;
  logic rst_n;

  cvi_in_if  in_bus();
  cvi_out_if out_bus();

  int  fail_count;
  int  pending;
  int  sent;
  bit  tx_idle;
  bit  rx_idle;
  bit  hold_off_req;

  // codes that recently got glyph rows, reused when filling the page
  logic [BYTE_W-1:0] glyph_codes[$];

  char_video_interface_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  char_video_interface_unit_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stall bursts plus one long hold-off on request
  initial begin
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic issue(
    input logic [CMD_W-1:0]  cmd,
    input logic [OFS_W-1:0]  ofs,
    input logic [VAL_W-1:0]  val,
    input logic [CELL_W-1:0] cell_idx,
    input logic [ROW_W-1:0]  row
  );
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.command  <= cmd;
    in_bus.offset   <= ofs;
    in_bus.value    <= val;
    in_bus.cell_req <= cell_idx;
    in_bus.row      <= row;
    do @(posedge clk); while (!in_bus.ready);
    sent++;
  endtask

  task automatic write_reg(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val);
    issue(cmd, OFS_W'($urandom), val, CELL_W'($urandom_range(0, 999)), ROW_W'($urandom));
  endtask

  task automatic access(input logic [CMD_W-1:0] cmd, input logic [OFS_W-1:0] ofs,
                        input logic [VAL_W-1:0] val);
    issue(cmd, ofs, val, CELL_W'($urandom_range(0, 999)), ROW_W'($urandom));
  endtask

  task automatic render(input logic [CELL_W-1:0] cell_idx, input logic [ROW_W-1:0] row);
    issue(CMD_RENDER, OFS_W'($urandom), VAL_W'($urandom), cell_idx, row);
  endtask

  initial begin
    logic [VAL_W-1:0]  val;
    logic [PTR_W-1:0]  home;
    logic [CELL_W-1:0] cell_idx;
    logic [BYTE_W-1:0] code;
    logic [ROW_W-1:0]  row;
    logic [CMD_W-1:0]  cmd;
    int  n;
    bit  held;

    rst_n           <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.command  <= '0;
    in_bus.offset   <= '0;
    in_bus.value    <= '0;
    in_bus.cell_req <= '0;
    in_bus.row      <= '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_off_req = 1'b0;
    held = 1'b0;
    sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: cleared state, extreme register words, pointer masking,
    // cmem gating of char writes, page wrap, colour formats, row limits
    render(0, 0);
    write_reg(CMD_OUT3, 16'hffff);
    write_reg(CMD_OUT5, 16'hffff);
    write_reg(CMD_OUT6, 16'hffff);
    access(CMD_PAGE_WR, 11'h000, 16'h00ff);
    access(CMD_PAGE_RD, 11'h000, 16'h0000);
    access(CMD_CHAR_WR, 11'h7ff, 16'hffff);
    access(CMD_CHAR_RD, 11'h007, 16'h0000);
    write_reg(CMD_OUT5, 16'h0001);
    access(CMD_PAGE_WR, 11'h7ff, 16'h005a);
    access(CMD_PAGE_RD, 11'h000, 16'h0000);
    access(CMD_CHAR_WR, 11'h000, 16'h00c3);
    write_reg(CMD_OUT5, 16'h0000);
    access(CMD_CHAR_WR, 11'h001, 16'h0077);
    access(CMD_CHAR_RD, 11'h001, 16'h0000);
    access(CMD_PAGE_WR, 11'h7ff, 16'h005a);
    write_reg(CMD_OUT7, 16'hffff);
    render(3, 0);
    write_reg(CMD_OUT3, 16'h0000);
    render(3, 0);
    write_reg(CMD_OUT3, 16'h0020);
    render(3, 0);
    write_reg(CMD_OUT3, 16'h0047);
    render(999, 15);
    write_reg(CMD_OUT5, 16'h0020);
    render(3, 15);
    issue(4'd9, 11'h7ff, 16'hffff, 10'd999, 4'hf);
    issue(4'd15, 11'h000, 16'h0000, 10'd0, 4'h0);

    while (sent < ITEM_TARGET) begin
      if (sent > ITEM_TARGET - CALM_ITEMS) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else begin
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
      end
      if (!held && sent > 500) begin
        held = 1'b1;
        hold_off_req = 1'b1;
      end
      case ($urandom_range(0, 7))
        0, 1, 2: begin
          // glyph load: cmem on, pointer to a cell, set its code, fill rows 0..7
          write_reg(CMD_OUT5, VAL_W'($urandom) | 16'h0001);
          write_reg(CMD_OUT6, VAL_W'($urandom));
          code = BYTE_W'($urandom);
          access(CMD_PAGE_WR, OFS_W'($urandom), {8'($urandom), code});
          glyph_codes.push_back(code);
          if (glyph_codes.size() > 16) void'(glyph_codes.pop_front());
          for (int k = 0; k < 8; k++) begin
            access(CMD_CHAR_WR, {8'($urandom), 3'(k)}, VAL_W'($urandom));
          end
          if ($urandom_range(0, 1) == 0) access(CMD_CHAR_RD, OFS_W'($urandom), VAL_W'($urandom));
          if ($urandom_range(0, 3) == 0) access(CMD_PAGE_RD, OFS_W'($urandom), VAL_W'($urandom));
        end
        3, 4, 5, 6: begin
          // text: cmem off, place codes on screen cells and draw their rows
          write_reg(CMD_OUT5, VAL_W'($urandom) & 16'hfffe);
          if ($urandom_range(0, 1) == 0) write_reg(CMD_OUT3, VAL_W'($urandom));
          val = VAL_W'($urandom);
          home = val[PTR_W-1:0] & 11'h7fc;
          write_reg(CMD_OUT7, val);
          n = $urandom_range(1, 4);
          for (int k = 0; k < n; k++) begin
            cell_idx = CELL_W'($urandom_range(0, 999));
            if (glyph_codes.size() > 0 && $urandom_range(0, 4) != 0)
              code = glyph_codes[$urandom_range(0, glyph_codes.size() - 1)];
            else
              code = BYTE_W'($urandom);
            access(CMD_PAGE_WR, PTR_W'(home + cell_idx), {8'($urandom), code});
            repeat ($urandom_range(1, 4)) begin
              row = ($urandom_range(0, 1) == 0) ? ROW_W'($urandom_range(0, 7)) : ROW_W'($urandom);
              render(cell_idx, row);
            end
            if ($urandom_range(0, 3) == 0)
              access(CMD_PAGE_RD, PTR_W'(home + cell_idx), VAL_W'($urandom));
          end
        end
        default: begin
          // noise: any command with any field contents
          repeat ($urandom_range(3, 8)) begin
            if ($urandom_range(0, 15) == 0) cmd = CMD_W'($urandom_range(9, 15));
            else cmd = CMD_W'($urandom_range(0, 8));
            issue(cmd, OFS_W'($urandom), VAL_W'($urandom), CELL_W'($urandom_range(0, 999)),
                  ROW_W'($urandom));
          end
        end
      endcase
    end
    in_bus.valid <= 1'b0;

    // let the checker record the last accepted beat before looking at pending
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
